// ----- design/touch_sample_averager_macros.svh -----
// Assertion macros used by the checker file tsa_chk.sv.
`ifndef TOUCH_SAMPLE_AVERAGER_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGER_MACROS_SVH

// Implication in the same cycle.
`define TSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define TSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tsa_pkg.sv -----
`timescale 1ns / 1ps

package tsa_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned MASK_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FIELD_W-1:0] EVT_ABS       = 16'd3;
  localparam logic [FIELD_W-1:0] CODE_X        = 16'd0;
  localparam logic [FIELD_W-1:0] CODE_Y        = 16'd1;
  localparam logic [FIELD_W-1:0] CODE_PRESSURE = 16'd24;

  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_P = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] event_type;
    logic [FIELD_W-1:0] event_code;
    logic [FIELD_W-1:0] event_value;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] x_average;
    logic [FIELD_W-1:0] y_average;
    logic [FIELD_W-1:0] pressure_average;
    logic [MASK_W-1:0]  empty_mask;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_AVG,
    ST_OUT
  } state_e;

endpackage

// ----- design/touch_sample_averager.sv -----
`timescale 1ns / 1ps

// Touch sample averager.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes absolute touch events.
// X and Y samples are divided by x_scale / y_scale and summed per axis; nonzero
// pressure samples are summed as they are. A pressure sample of zero (release)
// produces one result on the output channel (out_valid_o / out_stall_i /
// out_data_o) with the truncated means and the empty-axis mask, then clears
// all sums and counts. Other events produce nothing.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_index_i
// (0 x_scale, 1 y_scale); write only while the block is idle.
// One restoring divider does one quotient bit per cycle. An ignored event or a
// nonzero pressure sample is taken without leaving idle; an X or Y sample is
// divided by its scale; a release divides each nonempty axis sum by its count,
// X, Y, then pressure. in_stall_o is high while an item is in work.
// A finished result sits in the output register; the next event is taken while
// it waits. A release waits for that register to free up under out_stall_i.
// Reset: scales return to 1, sums and counts to zero, no result pending.
module touch_sample_averager #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tsa_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tsa_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tsa_pkg::FIELD_W-1:0]   cfg_data_i
);
  import tsa_pkg::*;

  localparam int unsigned SAMPLE_W = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int unsigned DEN_W    = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

  state_e state_q, state_d;

  logic [FIELD_W-1:0]    x_scale_q, y_scale_q, scale_eff;
  logic [SUM_W-1:0]      sum_q [3];
  logic [COUNT_BITS-1:0] cnt_q [3];
  logic [FIELD_W-1:0]    avg_q [3];
  logic [MASK_W-1:0]     mask_q;
  logic [1:0]            ax_q, in_ax, sel_ax;
  logic                  run_q;
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  accept, is_hit, is_abs;
  logic [FIELD_W-1:0]    samp;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  cnt_full;

  logic                  div_start, div_done;
  logic [SUM_W-1:0]      div_dividend, div_quot;
  logic [DEN_W-1:0]      div_divisor;

  logic                  acc_en, release_go, avg_we, empty_set, advance, out_load;
  logic [SUM_W-1:0]      acc_addend;
  logic [FIELD_W-1:0]    avg_val;

  tsa_div #(.DEN_W(DEN_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    is_abs = in_data_i.event_type == EVT_ABS;
    case (in_data_i.event_code)
      CODE_X:  in_ax = AX_X;
      CODE_Y:  in_ax = AX_Y;
      default: in_ax = AX_P;
    endcase
    is_hit = is_abs && (in_data_i.event_code == CODE_X || in_data_i.event_code == CODE_Y ||
                        in_data_i.event_code == CODE_PRESSURE);
    samp   = FIELD_W'(in_data_i.event_value[SAMPLE_W-1:0]);
    sel_ax = (state_q == ST_IDLE) ? in_ax : ax_q;
    cur_cnt  = cnt_q[sel_ax];
    cnt_full = &cur_cnt;
    scale_eff = (in_ax == AX_X) ? x_scale_q : y_scale_q;
    if (scale_eff == '0) begin
      scale_eff = FIELD_W'(1);
    end
  end

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = SUM_W'(samp);
    div_divisor  = DEN_W'(scale_eff);
    acc_en       = 1'b0;
    acc_addend   = SUM_W'(samp);
    release_go   = 1'b0;
    avg_we       = 1'b0;
    avg_val      = '0;
    empty_set    = 1'b0;
    advance      = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_hit) begin
          if (in_ax != AX_P) begin
            div_start = !cnt_full;
          end else if (samp != '0) begin
            acc_en = !cnt_full;
          end else begin
            release_go = 1'b1;
          end
        end
      end
      ST_SCALE: begin
        acc_en     = div_done;
        acc_addend = div_quot;
      end
      ST_AVG: begin
        div_dividend = sum_q[ax_q];
        div_divisor  = DEN_W'(cur_cnt);
        if (!run_q) begin
          if (cur_cnt == '0) begin
            empty_set = 1'b1;
            avg_we    = 1'b1;
            advance   = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end else if (div_done) begin
          avg_we  = 1'b1;
          avg_val = div_quot[FIELD_W-1:0];
          advance = 1'b1;
        end
      end
      ST_OUT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_SCALE;
        end else if (release_go) begin
          state_d = ST_AVG;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_AVG: begin
        if (advance && ax_q == AX_P) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_scale_q   <= FIELD_W'(1);
      y_scale_q   <= FIELD_W'(1);
      ax_q        <= AX_X;
      run_q       <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_X_SCALE: x_scale_q <= cfg_data_i;
          REG_Y_SCALE: y_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (div_start && state_q == ST_IDLE) begin
        ax_q <= in_ax;
      end
      if (release_go) begin
        ax_q   <= AX_X;
        run_q  <= 1'b0;
        mask_q <= '0;
      end
      if (state_q == ST_AVG) begin
        if (div_start) begin
          run_q <= 1'b1;
        end
        if (advance) begin
          run_q <= 1'b0;
          ax_q  <= ax_q + 2'd1;
        end
        if (empty_set) begin
          mask_q[ax_q] <= 1'b1;
        end
      end
      if (acc_en) begin
        sum_q[sel_ax] <= sum_q[sel_ax] + acc_addend;
        cnt_q[sel_ax] <= cur_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
          cnt_q[i] <= '0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_we) begin
      avg_q[ax_q] <= avg_val;
    end
    if (out_load) begin
      out_q.x_average        <= avg_q[AX_X];
      out_q.y_average        <= avg_q[AX_Y];
      out_q.pressure_average <= avg_q[AX_P];
      out_q.empty_mask       <= mask_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/tsa_div.sv -----
`timescale 1ns / 1ps

module tsa_div #(
  parameter int unsigned DEN_W = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tsa_pkg::SUM_W-1:0]  dividend_i,
  input  logic [DEN_W-1:0]           divisor_i,
  output logic                       done_o,
  output logic [tsa_pkg::SUM_W-1:0]  quot_o
);
  import tsa_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, acc_q[SUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    acc_d = {acc_q[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// ----- design/tsa_chk.sv -----
`timescale 1ns / 1ps

`include "touch_sample_averager_macros.svh"

module tsa_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input tsa_pkg::in_t                  in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input tsa_pkg::out_t                 out_data_o
);
  import tsa_pkg::*;

  logic in_xfer, ignored, empty_ok;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign ignored = in_data_i.event_type != EVT_ABS ||
                   (in_data_i.event_code != CODE_X && in_data_i.event_code != CODE_Y &&
                    in_data_i.event_code != CODE_PRESSURE);
  assign empty_ok = (!out_data_o.empty_mask[0] || out_data_o.x_average == '0) &&
                    (!out_data_o.empty_mask[1] || out_data_o.y_average == '0) &&
                    (!out_data_o.empty_mask[2] || out_data_o.pressure_average == '0);

  `TSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `TSA_ASSERT_NEXT(a_ignored_free, clk_i, rst_ni, in_xfer && ignored, !in_stall_o, "ignored event kept the block busy")
  `TSA_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_o, empty_ok, "empty axis with nonzero average")
  `TSA_ASSERT_IMPL(a_result_busy, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without release work")

endmodule

bind touch_sample_averager tsa_chk u_tsa_chk (.*);

// ----- sim/touch_sample_averager_test.sv -----
`timescale 1ns / 1ps

module touch_sample_averager_test;
  import tsa_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned PHASE_ITEMS  = 310;
  localparam logic [15:0] COUNT_FULL   = 16'hFFFF;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    in_t         ev;
    logic        typed;
    out_t        avg;
    logic [15:0] x_scale;
    logic [15:0] y_scale;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_data;

  logic [15:0] x_scale_q = 16'd1;
  logic [15:0] y_scale_q = 16'd1;
  logic [31:0] x_sum = '0;
  logic [31:0] y_sum = '0;
  logic [31:0] p_sum = '0;
  logic [15:0] x_cnt = '0;
  logic [15:0] y_cnt = '0;
  logic [15:0] p_cnt = '0;

  out_t      pending_averages[$];
  stim_row_t directed_rows[$];
  out_t      expected_avg;
  int        mismatches = 0;
  int        send_pct = 0;
  int        recv_pct = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  touch_sample_averager DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void add_sample(inout logic [31:0] sum, inout logic [15:0] cnt,
                                     input logic [15:0] sample);
    if (cnt != COUNT_FULL) begin
      sum = sum + 32'(sample);
      cnt = cnt + 16'd1;
    end
  endfunction

  function automatic logic [15:0] mean_of(input logic [31:0] sum, input logic [15:0] cnt);
    if (cnt == 16'd0) begin
      return 16'd0;
    end
    return 16'(sum / 32'(cnt));
  endfunction

  function automatic bit predict_touch(input in_t ev, output out_t avg);
    logic [15:0] div;
    avg = '0;
    if (ev.event_type != EVT_ABS) begin
      return 1'b0;
    end
    if (ev.event_code == CODE_X) begin
      div = (x_scale_q == 16'd0) ? 16'd1 : x_scale_q;
      add_sample(x_sum, x_cnt, ev.event_value / div);
      return 1'b0;
    end
    if (ev.event_code == CODE_Y) begin
      div = (y_scale_q == 16'd0) ? 16'd1 : y_scale_q;
      add_sample(y_sum, y_cnt, ev.event_value / div);
      return 1'b0;
    end
    if (ev.event_code != CODE_PRESSURE) begin
      return 1'b0;
    end
    if (ev.event_value != 16'd0) begin
      add_sample(p_sum, p_cnt, ev.event_value);
      return 1'b0;
    end
    avg.x_average        = mean_of(x_sum, x_cnt);
    avg.y_average        = mean_of(y_sum, y_cnt);
    avg.pressure_average = mean_of(p_sum, p_cnt);
    avg.empty_mask       = {p_cnt == 16'd0, y_cnt == 16'd0, x_cnt == 16'd0};
    x_sum = '0;
    y_sum = '0;
    p_sum = '0;
    x_cnt = '0;
    y_cnt = '0;
    p_cnt = '0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return rand16();
    endcase
  endfunction

  function automatic logic [15:0] rand_pressure();
    logic [15:0] v;
    v = rand_sample();
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic stim_row_t item_row(input logic [15:0] t, input logic [15:0] c,
                                         input logic [15:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.ev = '{event_type: t, event_code: c, event_value: v};
    return r;
  endfunction

  function automatic stim_row_t release_row(input logic [15:0] xa, input logic [15:0] ya,
                                            input logic [15:0] pa, input logic [2:0] m);
    stim_row_t r;
    r = item_row(EVT_ABS, CODE_PRESSURE, 16'd0);
    r.typed = 1'b1;
    r.avg = '{x_average: xa, y_average: ya, pressure_average: pa, empty_mask: m};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [15:0] xs, input logic [15:0] ys);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.x_scale = xs;
    r.y_scale = ys;
    return r;
  endfunction

  task automatic send_event(input in_t ev, input logic typed, input out_t typed_avg);
    out_t avg;
    bit   produced;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = predict_touch(ev, avg);
    if (typed) begin
      pending_averages.push_back(typed_avg);
    end else if (produced) begin
      pending_averages.push_back(avg);
    end
  endtask

  task automatic send_plain(input logic [15:0] t, input logic [15:0] c,
                            input logic [15:0] v);
    send_event('{event_type: t, event_code: c, event_value: v}, 1'b0, '0);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scales(input logic [15:0] xs, input logic [15:0] ys);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_X_SCALE;
    cfg_data  <= xs;
    @(negedge clk);
    cfg_index <= REG_Y_SCALE;
    cfg_data  <= ys;
    @(negedge clk);
    cfg_we    <= 1'b0;
    x_scale_q = xs;
    y_scale_q = ys;
  endtask

  task automatic run_random(input logic [15:0] xs, input logic [15:0] ys, input int spct,
                            input int rpct, input int hold_cycles);
    int          counted;
    int          samples;
    logic [15:0] t;
    logic [15:0] c;
    end_burst();
    set_scales(xs, ys);
    @(posedge clk);
    send_pct  = spct;
    recv_pct  = rpct;
    hold_left = hold_cycles;
    counted   = 0;
    while (counted < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        t = ($urandom_range(0, 2) == 0) ? EVT_ABS : rand16();
        case ($urandom_range(0, 3))
          0: c = CODE_X;
          1: c = CODE_Y;
          2: c = CODE_PRESSURE;
          default: c = rand16();
        endcase
        send_plain(t, c, rand_sample());
        if (t == EVT_ABS && (c == CODE_X || c == CODE_Y || c == CODE_PRESSURE)) begin
          counted++;
        end
      end else begin
        samples = $urandom_range(0, 6);
        repeat (samples) begin
          case ($urandom_range(0, 2))
            0: send_plain(EVT_ABS, CODE_X, rand_sample());
            1: send_plain(EVT_ABS, CODE_Y, rand_sample());
            default: send_plain(EVT_ABS, CODE_PRESSURE, rand_pressure());
          endcase
        end
        send_plain(EVT_ABS, CODE_PRESSURE, 16'd0);
        counted += samples + 1;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, out_data);
        mismatches++;
      end else begin
        expected_avg = pending_averages.pop_front();
        check_field("x_average", expected_avg.x_average, out_data.x_average);
        check_field("y_average", expected_avg.y_average, out_data.y_average);
        check_field("pressure_average", expected_avg.pressure_average,
                    out_data.pressure_average);
        check_field("empty_mask", 16'(expected_avg.empty_mask), 16'(out_data.empty_mask));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_X_SCALE;
    cfg_data  = '0;

    directed_rows.push_back(release_row(16'd0, 16'd0, 16'd0, 3'd7));
    directed_rows.push_back(item_row(16'd0, CODE_X, 16'd5));
    directed_rows.push_back(item_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(item_row(EVT_ABS, 16'd2, 16'd123));
    directed_rows.push_back(item_row(EVT_ABS, 16'hFFFF, 16'd0));
    directed_rows.push_back(item_row(16'h0103, CODE_PRESSURE, 16'd0));
    directed_rows.push_back(item_row(EVT_ABS, CODE_X, 16'hFFFF));
    directed_rows.push_back(item_row(EVT_ABS, CODE_Y, 16'hFFFF));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'hFFFF));
    directed_rows.push_back(release_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0));
    directed_rows.push_back(item_row(EVT_ABS, CODE_X, 16'd0));
    directed_rows.push_back(release_row(16'd0, 16'd0, 16'd0, 3'd6));
    directed_rows.push_back(item_row(EVT_ABS, CODE_Y, 16'd100));
    directed_rows.push_back(item_row(EVT_ABS, CODE_Y, 16'd201));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'd1));
    directed_rows.push_back(release_row(16'd0, 16'd150, 16'd1, 3'd1));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'hFFFF));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'd1));
    directed_rows.push_back(release_row(16'd0, 16'd0, 16'd32768, 3'd3));
    directed_rows.push_back(cfg_row(16'hFFFF, 16'd0));
    directed_rows.push_back(item_row(EVT_ABS, CODE_X, 16'hFFFF));
    directed_rows.push_back(item_row(EVT_ABS, CODE_X, 16'hFFFE));
    directed_rows.push_back(item_row(EVT_ABS, CODE_Y, 16'd1234));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'd5));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'd0));
    directed_rows.push_back(cfg_row(16'd256, 16'd16));
    directed_rows.push_back(item_row(EVT_ABS, CODE_X, 16'h1234));
    directed_rows.push_back(item_row(EVT_ABS, CODE_Y, 16'hFFFF));
    directed_rows.push_back(item_row(EVT_ABS, CODE_PRESSURE, 16'd0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        end_burst();
        set_scales(directed_rows[i].x_scale, directed_rows[i].y_scale);
      end else begin
        send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].avg);
      end
    end

    run_random(16'd1, 16'd1, 23, 69, 0);
    run_random(16'hFFFF, 16'hFFFF, 23, 69, 0);
    run_random(16'd0, 16'd0, 69, 23, 0);
    run_random(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)), 69, 23, 0);
    run_random(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 40)), 0, 0, 400);
    run_random(16'($urandom_range(1, 65535)), 16'd1, 0, 0, 0);

    end_burst();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tsa_pkg.sv
design/tsa_div.sv
design/touch_sample_averager.sv
design/tsa_chk.sv
sim/touch_sample_averager_test.sv
